// File: src/dmm_pkg.sv
package dmm_pkg;

    localparam int MAX_NODES       = 256;
    localparam int ALPHABET_SIZE   = 5;
    localparam int MAX_PATTERN_LEN = 16;

    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int CNT_W       = NODE_W + 1;
    localparam int SYM_W       = 3;
    localparam int POS_W       = 32;
    localparam int PID_W       = 9;
    localparam int LEN_W       = $clog2(MAX_PATTERN_LEN + 2);
    localparam int STR_W       = (MAX_PATTERN_LEN + 1) * SYM_W;
    localparam int SCAN_W      = MAX_PATTERN_LEN * SYM_W;
    localparam int CHILD_DEPTH = MAX_NODES * ALPHABET_SIZE;
    localparam int CADDR_W     = $clog2(CHILD_DEPTH);

    typedef enum logic [1:0] {
        CMD_PAT_SYM  = 2'd0,
        CMD_PAT_END  = 2'd1,
        CMD_TEXT_SYM = 2'd2,
        CMD_RESTART  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_MATCH = 2'd0,
        KIND_REG   = 2'd1,
        KIND_FULL  = 2'd2
    } t_kind;

    typedef struct packed {
        t_cmd             command;
        logic [SYM_W-1:0] symbol;
    } t_in_req;

    typedef struct packed {
        t_kind            kind;
        logic [POS_W-1:0] start_position;
        logic [PID_W-1:0] pattern_number;
        logic             last;
    } t_out_req;

    typedef struct packed {
        logic               child_rd;
        logic               child_wr;
        logic [CADDR_W-1:0] child_addr;
        logic [NODE_W-1:0]  child_node;
        logic               pid_rd;
        logic               pid_wr;
        logic [NODE_W-1:0]  pid_addr;
        logic [PID_W-1:0]   pid_data;
    } t_trie_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PAT_CHK,
        S_END_CHK,
        S_PUSH,
        S_GO_RD,
        S_GO_CHK,
        S_MT_RD,
        S_MT_CHK,
        S_MT_PID,
        S_FLUSH
    } t_state;

    function automatic logic [CADDR_W-1:0] child_addr(
        input logic [NODE_W-1:0] node,
        input logic [SYM_W-1:0]  sym
    );
        return CADDR_W'(node) * CADDR_W'(ALPHABET_SIZE) + CADDR_W'(sym);
    endfunction

endpackage

// File: src/dmm_trie.sv
module dmm_trie (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dmm_pkg::t_trie_req          i_req,
    output logic                        o_busy,
    output logic                        o_child_valid,
    output logic [dmm_pkg::NODE_W-1:0]  o_child_node,
    output logic [dmm_pkg::PID_W-1:0]   o_pid
);

    logic [dmm_pkg::NODE_W:0]          r_child_mem [dmm_pkg::CHILD_DEPTH];
    logic [dmm_pkg::NODE_W:0]          r_child_q;
    logic [dmm_pkg::PID_W-1:0]         r_pid_mem [dmm_pkg::MAX_NODES];
    logic [dmm_pkg::PID_W-1:0]         r_pid_q;
    logic                              r_busy;
    logic [dmm_pkg::CADDR_W-1:0]       r_clr;

    // clearing pass over the child table after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_clr  <= '0;
        end else if (r_busy) begin
            if (r_clr == dmm_pkg::CADDR_W'(dmm_pkg::CHILD_DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_child_mem[r_clr] <= '0;
        end else if (i_req.child_wr) begin
            r_child_mem[i_req.child_addr] <= {1'b1, i_req.child_node};
        end
        if (i_req.child_rd) begin
            r_child_q <= r_child_mem[i_req.child_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.pid_wr) begin
            r_pid_mem[i_req.pid_addr] <= i_req.pid_data;
        end
        if (i_req.pid_rd) begin
            r_pid_q <= r_pid_mem[i_req.pid_addr];
        end
    end

    assign o_busy        = r_busy;
    assign o_child_valid = r_child_q[dmm_pkg::NODE_W];
    assign o_child_node  = r_child_q[dmm_pkg::NODE_W-1:0];
    assign o_pid         = r_pid_q;

    a_no_access_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !(i_req.child_rd || i_req.child_wr || i_req.pid_wr))
        else $error("trie access during clearing pass");

endmodule

// File: src/dmm_outreg.sv
module dmm_outreg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  dmm_pkg::t_out_req  i_data,
    output logic               o_ready,
    input  logic               i_stall,
    output logic               o_valid,
    output dmm_pkg::t_out_req  o_data
);

    logic              r_valid;
    dmm_pkg::t_out_req r_data;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: src/dmm_seq.sv
module dmm_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  dmm_pkg::t_in_req            i_in_data,
    output logic                        o_in_stall,
    output dmm_pkg::t_trie_req          o_req,
    input  logic                        i_busy,
    input  logic                        i_child_valid,
    input  logic [dmm_pkg::NODE_W-1:0]  i_child_node,
    input  logic [dmm_pkg::PID_W-1:0]   i_pid,
    output logic                        o_push,
    output dmm_pkg::t_out_req           o_push_data,
    input  logic                        i_push_ready
);

    dmm_pkg::t_state                r_state, n_state;
    logic [dmm_pkg::SYM_W-1:0]      r_sym, n_sym;
    logic [dmm_pkg::STR_W-1:0]      r_w, n_w;
    logic [dmm_pkg::LEN_W-1:0]      r_len, n_len;
    logic [dmm_pkg::LEN_W-1:0]      r_j, n_j;
    logic [dmm_pkg::NODE_W-1:0]     r_node, n_node;
    logic [dmm_pkg::SCAN_W-1:0]     r_scan_str, n_scan_str;
    logic [dmm_pkg::LEN_W-1:0]      r_scan_len, n_scan_len;
    logic [dmm_pkg::POS_W-1:0]      r_tp, n_tp;
    logic [dmm_pkg::NODE_W-1:0]     r_cur, n_cur;
    logic [dmm_pkg::LEN_W-1:0]      r_cur_len, n_cur_len;
    logic [dmm_pkg::CNT_W-1:0]      r_ncount, n_ncount;
    logic [dmm_pkg::PID_W-1:0]      r_pcount, n_pcount;
    logic                           r_pend_valid, n_pend_valid;
    dmm_pkg::t_out_req              r_pend, n_pend;
    dmm_pkg::t_out_req              r_res, n_res;

    logic [dmm_pkg::SYM_W-1:0]      w_walk_sym;
    logic [dmm_pkg::POS_W:0]        w_end;
    logic [dmm_pkg::POS_W:0]        w_st;
    logic [dmm_pkg::POS_W-1:0]      w_start;

    assign w_walk_sym = r_w[dmm_pkg::SYM_W * (r_j - 1'b1) +: dmm_pkg::SYM_W];

    // start = position + 1 - length, floored at zero
    always_comb begin
        w_end = {1'b0, r_tp} + 1'b1;
        w_st  = (w_end >= (dmm_pkg::POS_W+1)'(r_len)) ? w_end - (dmm_pkg::POS_W+1)'(r_len) : '0;
        w_start = w_st[dmm_pkg::POS_W] ? '1 : w_st[dmm_pkg::POS_W-1:0];
    end

    assign o_in_stall = (r_state != dmm_pkg::S_IDLE) || i_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dmm_pkg::S_IDLE;
            r_scan_len   <= '0;
            r_tp         <= '0;
            r_cur        <= '0;
            r_cur_len    <= '0;
            r_ncount     <= dmm_pkg::CNT_W'(1);
            r_pcount     <= '0;
            r_pend_valid <= 1'b0;
            r_len        <= '0;
            r_j          <= '0;
        end else begin
            r_state      <= n_state;
            r_scan_len   <= n_scan_len;
            r_tp         <= n_tp;
            r_cur        <= n_cur;
            r_cur_len    <= n_cur_len;
            r_ncount     <= n_ncount;
            r_pcount     <= n_pcount;
            r_pend_valid <= n_pend_valid;
            r_len        <= n_len;
            r_j          <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym      <= n_sym;
        r_w        <= n_w;
        r_node     <= n_node;
        r_scan_str <= n_scan_str;
        r_pend     <= n_pend;
        r_res      <= n_res;
    end

    always_comb begin
        logic adv;
        n_state      = r_state;
        n_sym        = r_sym;
        n_w          = r_w;
        n_len        = r_len;
        n_j          = r_j;
        n_node       = r_node;
        n_scan_str   = r_scan_str;
        n_scan_len   = r_scan_len;
        n_tp         = r_tp;
        n_cur        = r_cur;
        n_cur_len    = r_cur_len;
        n_ncount     = r_ncount;
        n_pcount     = r_pcount;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_res        = r_res;
        o_req        = '0;
        o_push       = 1'b0;
        o_push_data  = r_res;
        adv          = 1'b0;

        case (r_state)
            dmm_pkg::S_IDLE: begin
                if (i_in_valid && !i_busy) begin
                    case (i_in_data.command)
                        dmm_pkg::CMD_PAT_SYM: begin
                            if (32'(i_in_data.symbol) < dmm_pkg::ALPHABET_SIZE &&
                                r_cur_len < dmm_pkg::LEN_W'(dmm_pkg::MAX_PATTERN_LEN)) begin
                                n_sym            = i_in_data.symbol;
                                o_req.child_rd   = 1'b1;
                                o_req.child_addr = dmm_pkg::child_addr(r_cur, i_in_data.symbol);
                                n_state          = dmm_pkg::S_PAT_CHK;
                            end
                        end
                        dmm_pkg::CMD_PAT_END: begin
                            if (r_cur != '0) begin
                                o_req.pid_rd   = 1'b1;
                                o_req.pid_addr = r_cur;
                                n_state        = dmm_pkg::S_END_CHK;
                            end
                        end
                        dmm_pkg::CMD_TEXT_SYM: begin
                            if (32'(i_in_data.symbol) < dmm_pkg::ALPHABET_SIZE) begin
                                n_tp    = (r_tp == '1) ? r_tp : r_tp + 1'b1;
                                n_w     = {r_scan_str, i_in_data.symbol};
                                n_len   = r_scan_len + 1'b1;
                                n_j     = r_scan_len + 1'b1;
                                n_node  = '0;
                                n_state = dmm_pkg::S_GO_RD;
                            end
                        end
                        dmm_pkg::CMD_RESTART: begin
                            n_scan_len = '0;
                            n_tp       = '0;
                        end
                        default: ;
                    endcase
                end
            end
            dmm_pkg::S_PAT_CHK: begin
                if (i_child_valid) begin
                    n_cur     = i_child_node;
                    n_cur_len = r_cur_len + 1'b1;
                    n_state   = dmm_pkg::S_IDLE;
                end else if (r_ncount >= dmm_pkg::CNT_W'(dmm_pkg::MAX_NODES)) begin
                    n_res   = '{dmm_pkg::KIND_FULL, '0, '0, 1'b1};
                    n_state = dmm_pkg::S_PUSH;
                end else begin
                    o_req.child_wr   = 1'b1;
                    o_req.child_addr = dmm_pkg::child_addr(r_cur, r_sym);
                    o_req.child_node = r_ncount[dmm_pkg::NODE_W-1:0];
                    o_req.pid_wr     = 1'b1;
                    o_req.pid_addr   = r_ncount[dmm_pkg::NODE_W-1:0];
                    o_req.pid_data   = '0;
                    n_cur            = r_ncount[dmm_pkg::NODE_W-1:0];
                    n_cur_len        = r_cur_len + 1'b1;
                    n_ncount         = r_ncount + 1'b1;
                    n_state          = dmm_pkg::S_IDLE;
                end
            end
            dmm_pkg::S_END_CHK: begin
                o_req.pid_wr   = 1'b1;
                o_req.pid_addr = r_cur;
                if (i_pid == '0) begin
                    n_pcount       = r_pcount + 1'b1;
                    o_req.pid_data = r_pcount + 1'b1;
                    n_res          = '{dmm_pkg::KIND_REG, '0, r_pcount + 1'b1, 1'b1};
                end else begin
                    o_req.pid_data = r_pcount;
                    n_res          = '{dmm_pkg::KIND_REG, '0, r_pcount, 1'b1};
                end
                n_cur     = '0;
                n_cur_len = '0;
                n_state   = dmm_pkg::S_PUSH;
            end
            dmm_pkg::S_PUSH: begin
                if (i_push_ready) begin
                    o_push      = 1'b1;
                    o_push_data = r_res;
                    n_state     = dmm_pkg::S_IDLE;
                end
            end
            dmm_pkg::S_GO_RD: begin
                o_req.child_rd   = 1'b1;
                o_req.child_addr = dmm_pkg::child_addr(r_node, w_walk_sym);
                n_state          = dmm_pkg::S_GO_CHK;
            end
            dmm_pkg::S_GO_CHK: begin
                if (i_child_valid) begin
                    if (r_j == dmm_pkg::LEN_W'(1)) begin
                        n_scan_str = r_w[dmm_pkg::SCAN_W-1:0];
                        n_scan_len = r_len;
                        n_node     = '0;
                        n_j        = r_len;
                        n_state    = dmm_pkg::S_MT_RD;
                    end else begin
                        n_node  = i_child_node;
                        n_j     = r_j - 1'b1;
                        n_state = dmm_pkg::S_GO_RD;
                    end
                end else if (r_len == dmm_pkg::LEN_W'(1)) begin
                    n_scan_len = '0;
                    n_state    = dmm_pkg::S_FLUSH;
                end else begin
                    n_len   = r_len - 1'b1;
                    n_j     = r_len - 1'b1;
                    n_node  = '0;
                    n_state = dmm_pkg::S_GO_RD;
                end
            end
            dmm_pkg::S_MT_RD: begin
                o_req.child_rd   = 1'b1;
                o_req.child_addr = dmm_pkg::child_addr(r_node, w_walk_sym);
                n_state          = dmm_pkg::S_MT_CHK;
            end
            dmm_pkg::S_MT_CHK: begin
                if (i_child_valid) begin
                    if (r_j == dmm_pkg::LEN_W'(1)) begin
                        o_req.pid_rd   = 1'b1;
                        o_req.pid_addr = i_child_node;
                        n_state        = dmm_pkg::S_MT_PID;
                    end else begin
                        n_node  = i_child_node;
                        n_j     = r_j - 1'b1;
                        n_state = dmm_pkg::S_MT_RD;
                    end
                end else begin
                    adv = 1'b1;
                end
            end
            dmm_pkg::S_MT_PID: begin
                if (i_pid == '0) begin
                    adv = 1'b1;
                end else if (!r_pend_valid || i_push_ready) begin
                    if (r_pend_valid) begin
                        o_push      = 1'b1;
                        o_push_data = r_pend;
                    end
                    n_pend       = '{dmm_pkg::KIND_MATCH, w_start, i_pid, 1'b0};
                    n_pend_valid = 1'b1;
                    adv          = 1'b1;
                end
            end
            dmm_pkg::S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = dmm_pkg::S_IDLE;
                end else if (i_push_ready) begin
                    o_push       = 1'b1;
                    o_push_data  = r_pend;
                    o_push_data.last = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = dmm_pkg::S_IDLE;
                end
            end
            default: n_state = dmm_pkg::S_IDLE;
        endcase

        // next shorter suffix of the scan string
        if (adv) begin
            if (r_len == dmm_pkg::LEN_W'(1)) begin
                n_state = dmm_pkg::S_FLUSH;
            end else begin
                n_len   = r_len - 1'b1;
                n_j     = r_len - 1'b1;
                n_node  = '0;
                n_state = dmm_pkg::S_MT_RD;
            end
        end
    end

    a_push_only_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_push_ready)
        else $error("push into full output register");

    a_scan_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_len <= dmm_pkg::LEN_W'(dmm_pkg::MAX_PATTERN_LEN))
        else $error("scan string too long");

    a_walk_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dmm_pkg::S_GO_RD || r_state == dmm_pkg::S_MT_RD) |->
        (r_j != '0 && r_j <= r_len))
        else $error("walk index out of range");

    a_match_then_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dmm_pkg::S_IDLE) |-> !r_pend_valid)
        else $error("pending match left behind");

endmodule

// File: src/multi_pattern_dna_matcher.sv
// channel   | valid        | stall        | payload
// ----------+--------------+--------------+----------------------
// request   | i_in_valid   | o_in_stall   | i_in_data  (t_in_req)
// result    | o_out_valid  | i_out_stall  | o_out_data (t_out_req)
//
// pattern symbol: S_PAT_CHK, S_PUSH if node table full; end of pattern: S_END_CHK, S_PUSH
// text symbol: each suffix of the scan string is walked from the root, one
//   child-table read (S_GO_RD/S_MT_RD) and check (S_GO_CHK/S_MT_CHK) per symbol
// after reset all 1280 child-table entries are cleared, with o_in_stall high
// a full output register holds the walk; the next request is taken once the
//   last result sits in the output register
module multi_pattern_dna_matcher (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  dmm_pkg::t_in_req   i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output dmm_pkg::t_out_req  o_out_data,
    input  logic               i_out_stall
);

    dmm_pkg::t_trie_req            w_req;
    logic                          w_busy;
    logic                          w_child_valid;
    logic [dmm_pkg::NODE_W-1:0]    w_child_node;
    logic [dmm_pkg::PID_W-1:0]     w_pid;
    logic                          w_push;
    dmm_pkg::t_out_req             w_push_data;
    logic                          w_push_ready;

    dmm_trie u_trie (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (w_req),
        .o_busy        (w_busy),
        .o_child_valid (w_child_valid),
        .o_child_node  (w_child_node),
        .o_pid         (w_pid)
    );

    dmm_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_data     (i_in_data),
        .o_in_stall    (o_in_stall),
        .o_req         (w_req),
        .i_busy        (w_busy),
        .i_child_valid (w_child_valid),
        .i_child_node  (w_child_node),
        .i_pid         (w_pid),
        .o_push        (w_push),
        .o_push_data   (w_push_data),
        .i_push_ready  (w_push_ready)
    );

    dmm_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_ready (w_push_ready),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

endmodule

// File: test/testbench.sv
module testbench;

    localparam int RANDOM_ROUNDS = 12;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int MAX_MATCHES   = 16;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    dmm_pkg::t_in_req  in_data;
    logic              in_stall;
    logic              out_valid;
    dmm_pkg::t_out_req out_data;
    logic              out_stall;

    multi_pattern_dna_matcher dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_data (out_data),
        .i_out_stall(out_stall)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // trie and link state of the matcher
    logic       kid_ok  [dmm_pkg::CHILD_DEPTH];
    int         kid     [dmm_pkg::CHILD_DEPTH];
    logic       jump_ok [dmm_pkg::CHILD_DEPTH];
    int         jump    [dmm_pkg::CHILD_DEPTH];
    logic       fail_ok [dmm_pkg::MAX_NODES];
    int         fail_to [dmm_pkg::MAX_NODES];
    logic       out_ok  [dmm_pkg::MAX_NODES];
    int         out_to  [dmm_pkg::MAX_NODES];
    int         up_node [dmm_pkg::MAX_NODES];
    int         up_sym  [dmm_pkg::MAX_NODES];
    logic       is_end  [dmm_pkg::MAX_NODES];
    int         end_id  [dmm_pkg::MAX_NODES];
    int         depth   [dmm_pkg::MAX_NODES];
    int         nodes;
    int         cursor;
    int         scan;
    logic [31:0] pos;
    int         patterns;

    dmm_pkg::t_out_req pending_q[$];
    int         errors;
    int         cycles;
    int         out_gap;

    function automatic void clear_links();
        for (int i = 0; i < dmm_pkg::CHILD_DEPTH; i++) jump_ok[i] = 1'b0;
        for (int i = 0; i < dmm_pkg::MAX_NODES; i++) begin
            fail_ok[i] = 1'b0;
            out_ok[i]  = 1'b0;
        end
    endfunction

    function automatic void trie_reset();
        for (int i = 0; i < dmm_pkg::CHILD_DEPTH; i++) kid_ok[i] = 1'b0;
        for (int i = 0; i < dmm_pkg::MAX_NODES; i++) begin
            is_end[i] = 1'b0; end_id[i] = 0; depth[i] = 0;
            up_node[i] = 0; up_sym[i] = 0;
        end
        clear_links();
        nodes = 1; cursor = 0; scan = 0; pos = '0; patterns = 0;
    endfunction

    function automatic int fail_of(int v);
        int t;
        if (!fail_ok[v]) begin
            if (v == 0 || up_node[v] == 0) t = 0;
            else t = step_of(fail_of(up_node[v]), up_sym[v]);
            fail_to[v] = t;
            fail_ok[v] = 1'b1;
        end
        return fail_to[v];
    endfunction

    function automatic int step_of(int v, int s);
        int idx;
        int t;
        idx = v * dmm_pkg::ALPHABET_SIZE + s;
        if (!jump_ok[idx]) begin
            if (kid_ok[idx]) t = kid[idx];
            else if (v == 0) t = 0;
            else t = step_of(fail_of(v), s);
            jump[idx] = t;
            jump_ok[idx] = 1'b1;
        end
        return jump[idx];
    endfunction

    function automatic int out_of(int v);
        int s;
        int t;
        if (!out_ok[v]) begin
            s = fail_of(v);
            if (s == 0) t = 0;
            else if (is_end[s]) t = s;
            else t = out_of(s);
            out_to[v] = t;
            out_ok[v] = 1'b1;
        end
        return out_to[v];
    endfunction

    function automatic dmm_pkg::t_out_req mk(dmm_pkg::t_kind k, logic [31:0] st, int num,
                                             logic lst);
        dmm_pkg::t_out_req r;
        r.kind = k; r.start_position = st; r.pattern_number = dmm_pkg::PID_W'(num);
        r.last = lst;
        return r;
    endfunction

    function automatic void add_want(dmm_pkg::t_out_req r);
        pending_q.insert(pending_q.size(), r);
    endfunction

    // advances the trie model and queues the results of one request
    function automatic void predict_request(dmm_pkg::t_in_req rq);
        int sym;
        int idx;
        int v;
        int n;
        longint st;
        sym = int'(rq.symbol);
        case (rq.command)
            dmm_pkg::CMD_PAT_SYM: begin
                if (sym < dmm_pkg::ALPHABET_SIZE && depth[cursor] < dmm_pkg::MAX_PATTERN_LEN) begin
                    idx = cursor * dmm_pkg::ALPHABET_SIZE + sym;
                    if (kid_ok[idx]) cursor = kid[idx];
                    else if (nodes >= dmm_pkg::MAX_NODES)
                        add_want(mk(dmm_pkg::KIND_FULL, 0, 0, 1'b1));
                    else begin
                        n = nodes++;
                        up_node[n] = cursor; up_sym[n] = sym;
                        depth[n] = depth[cursor] + 1;
                        is_end[n] = 1'b0; end_id[n] = 0;
                        kid[idx] = n; kid_ok[idx] = 1'b1;
                        clear_links();
                        cursor = n;
                    end
                end
            end
            dmm_pkg::CMD_PAT_END: begin
                if (cursor != 0) begin
                    if (!is_end[cursor]) begin
                        patterns++;
                        is_end[cursor] = 1'b1;
                        clear_links();
                    end
                    end_id[cursor] = patterns;
                    cursor = 0;
                    add_want(mk(dmm_pkg::KIND_REG, 0, patterns, 1'b1));
                end
            end
            dmm_pkg::CMD_TEXT_SYM: begin
                if (sym < dmm_pkg::ALPHABET_SIZE) begin
                    n = 0;
                    if (pos != 32'hFFFF_FFFF) pos++;
                    scan = step_of(scan, sym);
                    v = scan;
                    while (v != 0 && n < MAX_MATCHES) begin
                        if (is_end[v]) begin
                            st = longint'(pos) + 1 - depth[v];
                            if (st < 0) st = 0;
                            add_want(mk(dmm_pkg::KIND_MATCH, st[31:0], end_id[v], 1'b0));
                            n++;
                        end
                        v = out_of(v);
                    end
                    if (n > 0) pending_q[$].last = 1'b1;
                end
            end
            default: begin
                scan = 0;
                pos = '0;
            end
        endcase
    endfunction

    task automatic report(string what, dmm_pkg::t_out_req got, dmm_pkg::t_out_req want);
        errors++;
        $display("mismatch %s: got %0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d", what,
                 got.kind, got.start_position, got.pattern_number, got.last,
                 want.kind, want.start_position, want.pattern_number, want.last);
    endtask

    task automatic send(dmm_pkg::t_cmd c, int s);
        int gap;
        gap = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= dmm_pkg::t_in_req'({c, 3'(s)});
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_request(dmm_pkg::t_in_req'({c, 3'(s)}));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    task automatic send_pattern(int len);
        for (int i = 0; i < len; i++) send(dmm_pkg::CMD_PAT_SYM, $urandom_range(0, 3));
        send(dmm_pkg::CMD_PAT_END, 0);
    endtask

    // result checker with random stall
    always @(posedge clk) begin
        dmm_pkg::t_out_req want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_q.size() == 0) begin
                report("unexpected", out_data, '0);
            end else begin
                want = pending_q.pop_front();
                if (out_data.kind !== want.kind) report("kind", out_data, want);
                else if (out_data.start_position !== want.start_position)
                    report("start", out_data, want);
                else if (out_data.pattern_number !== want.pattern_number)
                    report("number", out_data, want);
                else if (out_data.last !== want.last) report("last", out_data, want);
            end
            out_gap = $urandom_range(0, 14);
        end
        if (out_gap > 0) begin
            out_stall <= 1'b1;
            out_gap--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    typedef struct {
        dmm_pkg::t_cmd     c;
        int                s;
        logic              has_want;
        dmm_pkg::t_out_req want;
    } t_row;

    t_row rows[$];

    initial begin
        dmm_pkg::t_out_req none;
        none = '0;
        errors = 0; cycles = 0; out_gap = 0;
        rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
        trie_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // directed table
        rows = '{
            '{dmm_pkg::CMD_PAT_END,  0, 1'b0, none},                       // empty pattern
            '{dmm_pkg::CMD_TEXT_SYM, 0, 1'b0, none},
            '{dmm_pkg::CMD_PAT_SYM,  0, 1'b0, none},
            '{dmm_pkg::CMD_PAT_SYM,  1, 1'b0, none},
            '{dmm_pkg::CMD_PAT_END,  0, 1'b1, '{dmm_pkg::KIND_REG, 0, 1, 1'b1}},
            '{dmm_pkg::CMD_PAT_SYM,  4, 1'b0, none},
            '{dmm_pkg::CMD_PAT_END,  0, 1'b1, '{dmm_pkg::KIND_REG, 0, 2, 1'b1}},
            '{dmm_pkg::CMD_PAT_SYM,  7, 1'b0, none},                       // out of alphabet
            '{dmm_pkg::CMD_PAT_SYM,  0, 1'b0, none},
            '{dmm_pkg::CMD_PAT_SYM,  1, 1'b0, none},
            '{dmm_pkg::CMD_PAT_END,  0, 1'b1, '{dmm_pkg::KIND_REG, 0, 2, 1'b1}}, // repeated
            '{dmm_pkg::CMD_TEXT_SYM, 0, 1'b0, none},
            '{dmm_pkg::CMD_TEXT_SYM, 1, 1'b0, none},
            '{dmm_pkg::CMD_TEXT_SYM, 4, 1'b0, none},
            '{dmm_pkg::CMD_TEXT_SYM, 5, 1'b0, none},
            '{dmm_pkg::CMD_TEXT_SYM, 6, 1'b0, none},
            '{dmm_pkg::CMD_RESTART,  3, 1'b0, none},
            '{dmm_pkg::CMD_TEXT_SYM, 2, 1'b0, none},
            '{dmm_pkg::CMD_TEXT_SYM, 3, 1'b0, none}
        };
        foreach (rows[i]) begin
            send(rows[i].c, rows[i].s);
            if (rows[i].has_want && pending_q[$] !== rows[i].want)
                report("table", pending_q[$], rows[i].want);
        end
        wait_drained();
        // long pattern past the length limit
        for (int i = 0; i < dmm_pkg::MAX_PATTERN_LEN + 3; i++) send(dmm_pkg::CMD_PAT_SYM, 0);
        send(dmm_pkg::CMD_PAT_END, 0);
        for (int i = 0; i < 20; i++) send(dmm_pkg::CMD_TEXT_SYM, 0);
        wait_drained();
        // random: mostly patterns and text over a small alphabet
        for (int i = 0; i < RANDOM_ROUNDS; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: send_pattern($urandom_range(1, 4));
                3: send(dmm_pkg::t_cmd'($urandom_range(0, 3)), $urandom_range(0, 7));
                4: send(dmm_pkg::CMD_RESTART, $urandom_range(0, 7));
                default: for (int k = 0; k < 4; k++)
                    send(dmm_pkg::CMD_TEXT_SYM, $urandom_range(0, 4));
            endcase
            if (i == 6) wait_drained();
        end
        for (int i = 0; i < 10; i++) send(dmm_pkg::CMD_TEXT_SYM, $urandom_range(0, 3));
        wait_drained();
        if (errors == 0 && pending_q.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule

// File: filelist.f
src/dmm_pkg.sv
src/dmm_trie.sv
src/dmm_outreg.sv
src/dmm_seq.sv
src/multi_pattern_dna_matcher.sv
test/testbench.sv
